>>> hw/rtl/crop_pkg.sv
package crop_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;

  localparam int FIELD_W = 11;
  localparam int CW      = FIELD_W + 1;
  localparam int OP_W    = 3;
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XBW = XW + 1;
  localparam int YBW = YW + 1;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
  localparam logic [CFG_W-1:0] CFG_DIM_RESET = 8'd128;

  localparam logic [OP_W-1:0] OP_READ   = 3'd0;
  localparam logic [OP_W-1:0] OP_FILL   = 3'd1;
  localparam logic [OP_W-1:0] OP_INVERT = 3'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_W-1:0] OP_BLIT   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HEIGHT = 1'd1;

  typedef logic signed [CW-1:0] coord_t;

endpackage

>>> hw/rtl/crop_ram.sv
module crop_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/clipped_raster_op_engine.sv
// channel   direction  transfer when        payload
// command   in         start & !busy        in_op, in_left .. in_offset_y
// result    out        out_valid            out_read_data, out_in_range
// config    in         cfg_we               cfg_index, cfg_data
//
// outside the active area read and blit answer in the command state; else a read
// passes the point and read-wait states, a blit writes in the point state; fill and
// invert walk the clipped box, invert with a final flush write; clear writes one store
// entry per cycle. the walk is set by the single write port of the frame store.
// after reset a clearing pass writes 255 to every entry; busy is high.
// every item gives one result, shown for one cycle; the receiver cannot stall.
module clipped_raster_op_engine
  import crop_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [OP_W-1:0]             in_op,
  input  logic signed [FIELD_W-1:0]   in_left,
  input  logic signed [FIELD_W-1:0]   in_top,
  input  logic signed [FIELD_W-1:0]   in_right,
  input  logic signed [FIELD_W-1:0]   in_bottom,
  input  logic [PIX_W-1:0]            in_pixel_value,
  input  logic signed [FIELD_W-1:0]   in_offset_x,
  input  logic signed [FIELD_W-1:0]   in_offset_y,
  output logic                        out_valid,
  output logic [PIX_W-1:0]            out_read_data,
  output logic                        out_in_range,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]            cfg_data
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CMD    = 3'd1;
  localparam logic [2:0] S_POINT  = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_WALK   = 3'd4;
  localparam logic [2:0] S_FLUSH  = 3'd5;
  localparam logic [2:0] S_SWEEP  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [CFG_W-1:0] width_r, height_r;

  logic [OP_W-1:0]           op_r;
  logic signed [FIELD_W-1:0] left_r, top_r, right_r, bottom_r, dx_r, dy_r;
  logic [PIX_W-1:0]          value_r;

  logic [XW-1:0]  cur_x_r, cur_x_nxt, x_lo_r, x_lo_nxt;
  logic [YW-1:0]  cur_y_r, cur_y_nxt;
  logic [XBW-1:0] x_hi_r, x_hi_nxt;
  logic [YBW-1:0] y_hi_r, y_hi_nxt;
  logic           first_r, first_nxt;
  logic [AW-1:0]  prev_addr_r, prev_addr_nxt;
  logic [AW-1:0]  sweep_addr_r, sweep_addr_nxt;
  logic           sweep_report_r, sweep_report_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_data_r, out_data_nxt;
  logic             out_hit_r, out_hit_nxt;

  logic [XBW-1:0] w_eff;
  logic [YBW-1:0] h_eff;
  coord_t         weff_s, heff_s;
  coord_t         left_s, top_s, right_s, bottom_s;
  coord_t         pt_x, pt_y, x1, x2, y1, y2;
  logic           pt_hit, rect_ok;

  logic [YW+XBW-1:0] prod;
  logic [AW-1:0]     addr_cur;
  logic [XBW-1:0]    x_next;
  logic [YBW-1:0]    y_next;
  logic              last_pix;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [PIX_W-1:0] ram_wdata, ram_rdata;

  crop_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_frame (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // effective active area
  assign w_eff = (int'(width_r) > MAX_WIDTH) ? XBW'(MAX_WIDTH) : XBW'(width_r);
  assign h_eff = (int'(height_r) > MAX_HEIGHT) ? YBW'(MAX_HEIGHT) : YBW'(height_r);
  assign weff_s = $signed(CW'(w_eff));
  assign heff_s = $signed(CW'(h_eff));

  assign left_s   = CW'(left_r);
  assign top_s    = CW'(top_r);
  assign right_s  = CW'(right_r);
  assign bottom_s = CW'(bottom_r);

  assign pt_x = (op_r == OP_BLIT) ? left_s + CW'(dx_r) : left_s;
  assign pt_y = (op_r == OP_BLIT) ? top_s + CW'(dy_r) : top_s;
  assign pt_hit = (pt_x >= 0) && (pt_y >= 0) && (pt_x < weff_s) && (pt_y < heff_s);

  // clip to the active area
  assign x1 = (left_s < 0) ? coord_t'(0) : left_s;
  assign y1 = (top_s < 0) ? coord_t'(0) : top_s;
  assign x2 = (right_s > weff_s) ? weff_s : right_s;
  assign y2 = (bottom_s > heff_s) ? heff_s : bottom_s;
  assign rect_ok = (x1 < x2) && (y1 < y2);

  assign prod     = cur_y_r * w_eff;
  assign addr_cur = AW'(prod + (YW+XBW)'(cur_x_r));
  assign x_next   = XBW'(cur_x_r) + XBW'(1);
  assign y_next   = YBW'(cur_y_r) + YBW'(1);
  assign last_pix = (x_next == x_hi_r) && (y_next == y_hi_r);

  always_comb begin
    state_nxt        = state_r;
    cur_x_nxt        = cur_x_r;
    cur_y_nxt        = cur_y_r;
    x_lo_nxt         = x_lo_r;
    x_hi_nxt         = x_hi_r;
    y_hi_nxt         = y_hi_r;
    first_nxt        = first_r;
    prev_addr_nxt    = prev_addr_r;
    sweep_addr_nxt   = sweep_addr_r;
    sweep_report_nxt = sweep_report_r;
    out_valid_nxt    = 1'b0;
    out_data_nxt     = '0;
    out_hit_nxt      = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = addr_cur;
    ram_wdata        = value_r;
    ram_raddr        = addr_cur;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        case (op_r)
          OP_READ, OP_BLIT: begin
            if (pt_hit) begin
              cur_x_nxt = pt_x[XW-1:0];
              cur_y_nxt = pt_y[YW-1:0];
              state_nxt = S_POINT;
            end else begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          OP_FILL, OP_INVERT: begin
            if (rect_ok) begin
              cur_x_nxt = x1[XW-1:0];
              x_lo_nxt  = x1[XW-1:0];
              cur_y_nxt = y1[YW-1:0];
              x_hi_nxt  = x2[XBW-1:0];
              y_hi_nxt  = y2[YBW-1:0];
              first_nxt = 1'b1;
              state_nxt = S_WALK;
            end else begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          OP_CLEAR: begin
            sweep_addr_nxt   = '0;
            sweep_report_nxt = 1'b1;
            state_nxt        = S_SWEEP;
          end
          default: begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        endcase
      end
      S_POINT: begin
        if (op_r == OP_BLIT) begin
          ram_we        = 1'b1;
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_RDWAIT;
        end
      end
      S_RDWAIT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = ram_rdata;
        out_hit_nxt   = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_WALK: begin
        if (op_r == OP_FILL) begin
          ram_we = 1'b1;
        end else begin
          // write back the pixel read in the previous cycle
          ram_we    = !first_r;
          ram_waddr = prev_addr_r;
          ram_wdata = PIX_WHITE - ram_rdata;
        end
        prev_addr_nxt = addr_cur;
        first_nxt     = 1'b0;
        if (last_pix) begin
          if (op_r == OP_FILL) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            state_nxt = S_FLUSH;
          end
        end else if (x_next == x_hi_r) begin
          cur_x_nxt = x_lo_r;
          cur_y_nxt = y_next[YW-1:0];
        end else begin
          cur_x_nxt = x_next[XW-1:0];
        end
      end
      S_FLUSH: begin
        ram_we        = 1'b1;
        ram_waddr     = prev_addr_r;
        ram_wdata     = PIX_WHITE - ram_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr_r;
        ram_wdata = PIX_WHITE;
        if (sweep_addr_r == AW'(DEPTH - 1)) begin
          out_valid_nxt = sweep_report_r;
          state_nxt     = S_IDLE;
        end else begin
          sweep_addr_nxt = sweep_addr_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_SWEEP;
      sweep_addr_r   <= '0;
      sweep_report_r <= 1'b0;
      first_r        <= 1'b0;
      out_valid_r    <= 1'b0;
      width_r        <= CFG_DIM_RESET;
      height_r       <= CFG_DIM_RESET;
    end else begin
      state_r        <= state_nxt;
      sweep_addr_r   <= sweep_addr_nxt;
      sweep_report_r <= sweep_report_nxt;
      first_r        <= first_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_ACTIVE_WIDTH: begin
            width_r <= cfg_data;
          end
          REG_ACTIVE_HEIGHT: begin
            height_r <= cfg_data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r     <= in_op;
      left_r   <= in_left;
      top_r    <= in_top;
      right_r  <= in_right;
      bottom_r <= in_bottom;
      value_r  <= in_pixel_value;
      dx_r     <= in_offset_x;
      dy_r     <= in_offset_y;
    end
    cur_x_r     <= cur_x_nxt;
    cur_y_r     <= cur_y_nxt;
    x_lo_r      <= x_lo_nxt;
    x_hi_r      <= x_hi_nxt;
    y_hi_r      <= y_hi_nxt;
    prev_addr_r <= prev_addr_nxt;
    out_data_r  <= out_data_nxt;
    out_hit_r   <= out_hit_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;
  assign out_in_range  = out_hit_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_invert_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) && (op_r == OP_INVERT) && ram_we |-> ram_waddr != ram_raddr)
    else $error("invert write-back collides with its own read");

  a_hit_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_range |-> $past(state_r) == S_RDWAIT || $past(state_r) == S_POINT)
    else $error("in-range result without a pixel access");

endmodule

>>> tb/raster_op_checker.sv
`timescale 1ns / 100ps

module raster_op_checker
  import crop_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic [OP_W-1:0]           in_op,
  input  logic signed [FIELD_W-1:0] in_left,
  input  logic signed [FIELD_W-1:0] in_top,
  input  logic signed [FIELD_W-1:0] in_right,
  input  logic signed [FIELD_W-1:0] in_bottom,
  input  logic [PIX_W-1:0]          in_pixel_value,
  input  logic signed [FIELD_W-1:0] in_offset_x,
  input  logic signed [FIELD_W-1:0] in_offset_y,
  input  logic                      out_valid,
  input  logic [PIX_W-1:0]          out_read_data,
  input  logic                      out_in_range,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output int                        fail_count,
  output int                        results_due
);

  typedef struct packed {
    logic [PIX_W-1:0] read_data;
    logic             in_range;
  } pixel_result_t;

  logic [PIX_W-1:0] frame_copy [DEPTH];
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  pixel_result_t    pending_results [$];

  function automatic int span_x();
    return (int'(width_reg) > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
  endfunction

  function automatic int span_y();
    return (int'(height_reg) > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
  endfunction

  function automatic bit on_screen(int x, int y);
    return x >= 0 && y >= 0 && x < span_x() && y < span_y();
  endfunction

  function automatic int cell_index(int x, int y);
    return y * span_x() + x;
  endfunction

  // clip the half-open box to the active area, then walk it
  function automatic void paint_rect(int x1, int y1, int x2, int y2, bit invert,
                                     logic [PIX_W-1:0] colour);
    int i;
    if (x1 < 0) x1 = 0;
    if (y1 < 0) y1 = 0;
    if (x2 > span_x()) x2 = span_x();
    if (y2 > span_y()) y2 = span_y();
    for (int y = y1; y < y2; y++) begin
      for (int x = x1; x < x2; x++) begin
        i = cell_index(x, y);
        frame_copy[i] = invert ? PIX_WHITE - frame_copy[i] : colour;
      end
    end
  endfunction

  function automatic pixel_result_t predict_raster_op();
    pixel_result_t r;
    int tx;
    int ty;
    r = '0;
    case (in_op)
      OP_READ: begin
        if (on_screen(in_left, in_top)) begin
          r.read_data = frame_copy[cell_index(in_left, in_top)];
          r.in_range  = 1'b1;
        end
      end
      OP_FILL: paint_rect(in_left, in_top, in_right, in_bottom, 1'b0, in_pixel_value);
      OP_INVERT: paint_rect(in_left, in_top, in_right, in_bottom, 1'b1, '0);
      OP_CLEAR: begin
        foreach (frame_copy[i]) frame_copy[i] = PIX_WHITE;
      end
      OP_BLIT: begin
        tx = in_left + in_offset_x;
        ty = in_top + in_offset_y;
        if (on_screen(tx, ty)) begin
          frame_copy[cell_index(tx, ty)] = in_pixel_value;
          r.in_range = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst_n) begin
      foreach (frame_copy[i]) frame_copy[i] = PIX_WHITE;
      width_reg  = CFG_DIM_RESET;
      height_reg = CFG_DIM_RESET;
      pending_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_read_data !== want.read_data) begin
            $error("read_data mismatch: expected %0d, actual %0d",
                   want.read_data, out_read_data);
            fail_count++;
          end
          if (out_in_range !== want.in_range) begin
            $error("in_range mismatch: expected %0d, actual %0d",
                   want.in_range, out_in_range);
            fail_count++;
          end
        end
      end
      if (start && !busy) pending_results.push_back(predict_raster_op());
      if (cfg_we) begin
        if (cfg_index == REG_ACTIVE_WIDTH) width_reg = cfg_data;
        else if (cfg_index == REG_ACTIVE_HEIGHT) height_reg = cfg_data;
      end
    end
    results_due = pending_results.size();
  end

endmodule

>>> tb/clipped_raster_op_engine_test.sv
`timescale 1ns / 100ps

module clipped_raster_op_engine_test;
  import crop_pkg::*;

  localparam int QUIET_LIMIT = 100000;
  localparam int PHASES = 12;
  localparam int ITEMS_PER_PHASE = 62;
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct {
    logic [OP_W-1:0]           op;
    logic signed [FIELD_W-1:0] left;
    logic signed [FIELD_W-1:0] top;
    logic signed [FIELD_W-1:0] right;
    logic signed [FIELD_W-1:0] bottom;
    logic [PIX_W-1:0]          pixel_value;
    logic signed [FIELD_W-1:0] offset_x;
    logic signed [FIELD_W-1:0] offset_y;
  } command_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic [OP_W-1:0]           in_op = '0;
  logic signed [FIELD_W-1:0] in_left = '0;
  logic signed [FIELD_W-1:0] in_top = '0;
  logic signed [FIELD_W-1:0] in_right = '0;
  logic signed [FIELD_W-1:0] in_bottom = '0;
  logic [PIX_W-1:0]          in_pixel_value = '0;
  logic signed [FIELD_W-1:0] in_offset_x = '0;
  logic signed [FIELD_W-1:0] in_offset_y = '0;
  logic                      out_valid;
  logic [PIX_W-1:0]          out_read_data;
  logic                      out_in_range;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;
  int                        fail_count;
  int                        results_due;

  int quiet_cycles = 0;
  int area_w = MAX_WIDTH;
  int area_h = MAX_HEIGHT;
  bit gaps_on = 1'b1;

  clipped_raster_op_engine dut (.*);

  raster_op_checker watch (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic command_t make_cmd(logic [OP_W-1:0] op, int l, int t, int r, int b,
                                        int v, int dx, int dy);
    command_t c;
    c.op          = op;
    c.left        = FIELD_W'(l);
    c.top         = FIELD_W'(t);
    c.right       = FIELD_W'(r);
    c.bottom      = FIELD_W'(b);
    c.pixel_value = PIX_W'(v);
    c.offset_x    = FIELD_W'(dx);
    c.offset_y    = FIELD_W'(dy);
    return c;
  endfunction

  function automatic logic signed [FIELD_W-1:0] any_coord();
    return FIELD_W'($urandom);
  endfunction

  // a few outside the active area on either side
  function automatic logic signed [FIELD_W-1:0] near_coord(int span);
    return FIELD_W'(int'($urandom_range(0, span + 8)) - 4);
  endfunction

  function automatic logic signed [FIELD_W-1:0] nudge(logic signed [FIELD_W-1:0] base);
    return FIELD_W'(int'(base) + int'($urandom_range(0, 12)) - 2);
  endfunction

  function automatic command_t random_command();
    command_t c;
    int pick;
    pick          = $urandom_range(0, 99);
    c.pixel_value = PIX_W'($urandom);
    c.left        = near_coord(area_w);
    c.top         = near_coord(area_h);
    c.right       = any_coord();
    c.bottom      = any_coord();
    c.offset_x    = any_coord();
    c.offset_y    = any_coord();
    if (pick < 35) begin
      c.op = OP_READ;
      if ($urandom_range(0, 9) == 0) begin
        c.left = any_coord();
        c.top  = any_coord();
      end
    end else if (pick < 65) begin
      c.op = OP_BLIT;
      if ($urandom_range(0, 9) != 0) begin
        c.offset_x = FIELD_W'(int'($urandom_range(0, 8)) - 4);
        c.offset_y = FIELD_W'(int'($urandom_range(0, 8)) - 4);
      end else begin
        c.left = any_coord();
        c.top  = any_coord();
      end
    end else if (pick < 92) begin
      c.op = (pick < 80) ? OP_FILL : OP_INVERT;
      // mostly small boxes; a rare one has its corners anywhere in the coordinate range
      if ($urandom_range(0, 19) != 0) begin
        c.right  = nudge(c.left);
        c.bottom = nudge(c.top);
      end else begin
        c.left = any_coord();
        c.top  = any_coord();
      end
    end else if (pick < 94) begin
      c.op = OP_CLEAR;
    end else begin
      c.op   = OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      c.left = any_coord();
      c.top  = any_coord();
    end
    return c;
  endfunction

  // entered and left just after a falling edge; start stays high on return
  task automatic issue(command_t c);
    if (gaps_on && $urandom_range(0, 99) < 20) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    start          <= 1'b1;
    in_op          <= c.op;
    in_left        <= c.left;
    in_top         <= c.top;
    in_right       <= c.right;
    in_bottom      <= c.bottom;
    in_pixel_value <= c.pixel_value;
    in_offset_x    <= c.offset_x;
    in_offset_y    <= c.offset_y;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic set_area(int w, int h);
    start <= 1'b0;
    while (results_due != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ACTIVE_WIDTH;
    cfg_data  <= CFG_W'(w);
    @(negedge clk);
    cfg_index <= REG_ACTIVE_HEIGHT;
    cfg_data  <= CFG_W'(h);
    @(negedge clk);
    cfg_we <= 1'b0;
    area_w = (w > MAX_WIDTH) ? MAX_WIDTH : w;
    area_h = (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
  endtask

  task automatic directed_commands();
    issue(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_FILL, 0, 0, 4, 3, 8'h5a, 0, 0));
    issue(make_cmd(OP_READ, 3, 2, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_READ, 4, 2, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_INVERT, 2, 1, 6, 5, 0, 0, 0));
    issue(make_cmd(OP_READ, 2, 1, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_READ, 5, 4, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_BLIT, 100, 50, 0, 0, 0, 27, 77));
    issue(make_cmd(OP_READ, 127, 127, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_BLIT, -1024, 0, 0, 0, 8'h11, 1023, 0));
    issue(make_cmd(OP_BLIT, 1023, 1023, 0, 0, 8'h22, -1024, -1024));
    issue(make_cmd(OP_BLIT, 128, 0, 0, 0, 8'h33, 0, 0));
    issue(make_cmd(OP_READ, -1024, -1024, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_READ, 1023, 1023, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_READ, 128, 0, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_READ, 0, 128, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_FILL, 10, 10, 5, 20, 0, 0, 0));
    issue(make_cmd(OP_FILL, 10, 10, 10, 20, 0, 0, 0));
    issue(make_cmd(OP_FILL, -1024, -1024, 1023, 1023, 0, 0, 0));
    issue(make_cmd(OP_INVERT, 120, 120, 1023, 1023, 0, 0, 0));
    issue(make_cmd(OP_READ, 127, 127, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_FILL, 126, -5, 1023, 2, 255, 0, 0));
    issue(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_READ, 64, 64, 0, 0, 0, 0, 0));
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
      issue(make_cmd(OP_W'(op), $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom));
    end
  endtask

  initial begin
    int width_list [10]  = '{128, 1, 255, 0, 7, 13, 128, 1, 200, 64};
    int height_list [10] = '{128, 1, 255, 5, 0, 9, 1, 128, 31, 64};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int p = 0; p < PHASES; p++) begin
      if (p < 10) set_area(width_list[p], height_list[p]);
      else set_area($urandom_range(0, 255), $urandom_range(0, 255));
      // one long stretch without gaps
      gaps_on = !(p == 4 || p == 5);
      if (p == 0) directed_commands();
      repeat (ITEMS_PER_PHASE) issue(random_command());
    end
    start <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/crop_pkg.sv
hw/rtl/crop_ram.sv
hw/rtl/clipped_raster_op_engine.sv
tb/raster_op_checker.sv
tb/clipped_raster_op_engine_test.sv
